// ===== rtl/tspg_pkg.sv =====
package tspg_pkg;

  localparam int COUNT_BITS_DEF  = 20;
  localparam int PERIOD_BITS_DEF = 16;

  localparam int DEF_MIN_PERIOD  = 30;
  localparam int DEF_MAX_PERIOD  = 150;
  localparam int DEF_RAMP_STEPS  = 6400;
  localparam int DEF_PULSE_HIGH  = 5;
  localparam int DEF_HOME_PERIOD = 100;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PERIOD  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MAX_PERIOD  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_RAMP_STEPS  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_PULSE_HIGH  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_HOME_PERIOD = REG_IDX_W'(4);

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_TICK = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_MOVE = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_HOME = ACT_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ACCEL,
    PH_CONST,
    PH_DECEL,
    PH_HOME
  } phase_t;

  typedef enum logic [1:0] {
    FSM_READY,
    FSM_CALC,
    FSM_FINISH
  } fsm_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

endpackage

// ===== rtl/tspg_muldiv.sv =====
module tspg_muldiv
  import tspg_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PERIOD_BITS-1:0] diff,
  input  logic [COUNT_BITS-1:0]  index,
  input  logic [COUNT_BITS-1:0]  divisor,
  output logic                   done,
  output logic [PERIOD_BITS-1:0] quotient
);

  // quotient = diff * index / divisor, index < divisor, so the quotient fits PERIOD_BITS
  localparam int PW        = COUNT_BITS + PERIOD_BITS;
  localparam int STEPS_MAX = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
  localparam int CNT_W     = $clog2(STEPS_MAX + 1);

  md_state_t              state, state_next;
  logic                   done_next;
  logic [CNT_W-1:0]       cnt;
  logic [PW-1:0]          prod;
  logic [COUNT_BITS-1:0]  mplr;
  logic [PERIOD_BITS-1:0] dval;
  logic [COUNT_BITS-1:0]  dvsr;
  logic [COUNT_BITS-1:0]  rem;
  logic [PERIOD_BITS-1:0] quo;

  logic [PW-1:0]          mul_sum;
  logic [COUNT_BITS:0]    rem_sh;
  logic [COUNT_BITS:0]    rem_sub;
  logic                   rem_ge;
  logic                   last_mul;
  logic                   last_div;

  assign mul_sum  = {prod[PW-2:0], 1'b0} + (mplr[COUNT_BITS-1] ? PW'(dval) : '0);
  assign rem_sh   = {rem, prod[PERIOD_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, dvsr};
  assign rem_ge   = rem_sh >= {1'b0, dvsr};
  assign last_mul = cnt == CNT_W'(COUNT_BITS - 1);
  assign last_div = cnt == CNT_W'(PERIOD_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      MD_IDLE: begin
        if (start) state_next = MD_MUL;
      end
      MD_MUL: begin
        if (last_mul) state_next = MD_DIV;
      end
      MD_DIV: begin
        if (last_div) begin
          state_next = MD_IDLE;
          done_next  = 1'b1;
        end
      end
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (start) begin
          prod <= '0;
          mplr <= index;
          dval <= diff;
          dvsr <= divisor;
          cnt  <= '0;
        end
      end
      MD_MUL: begin
        prod <= mul_sum;
        mplr <= {mplr[COUNT_BITS-2:0], 1'b0};
        cnt  <= last_mul ? '0 : cnt + 1'b1;
        rem  <= mul_sum[PW-1:PERIOD_BITS];
      end
      MD_DIV: begin
        rem  <= rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quo  <= {quo[PERIOD_BITS-2:0], rem_ge};
        prod <= {prod[PW-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign quotient = quo;

endmodule

// ===== rtl/trapezoidal_step_pulse_generator.sv =====
// Step pulse generator with a trapezoidal speed profile. Each item on the slave stream is a
// one microsecond tick, a move command or a homing command, and each gives exactly one item
// on the master stream with the step and direction levels, busy, done and the step count.
// A tick or command that starts no ramp step goes from the ready state straight to finish;
// one that starts an accel or decel step first waits in the calc state for the shared
// shift-add multiplier and restoring divider that computes each ramp period. The slave side
// takes no new item until the current one is finished; the master side has an output
// register, but a result waiting there keeps the current item in finish. Configuration writes
// are taken at any time but are meant for when the block is idle.
module trapezoidal_step_pulse_generator
  import tspg_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF,
  localparam int IN_W  = ((COUNT_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_W = ((COUNT_BITS + 4 + 7) / 8) * 8,
  localparam int CFG_W = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // step_count, direction, limit_switch
  input  logic [ACT_W-1:0]     s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // step_level, dir_level, busy_res, done_res,
                                          // steps_taken
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [PERIOD_BITS-1:0] min_period, max_period, pulse_high, home_period;
  logic [COUNT_BITS-1:0]  ramp_steps;

  fsm_t                   fsm, fsm_next;
  phase_t                 phase, phase_next;
  logic [COUNT_BITS-1:0]  phase_index, phase_index_next;
  logic [COUNT_BITS-1:0]  accel_total, accel_total_next;
  logic [COUNT_BITS-1:0]  const_total, const_total_next;
  logic [PERIOD_BITS-1:0] tick_left, tick_left_next;
  logic [PERIOD_BITS-1:0] cur_period, cur_period_next;
  logic                   pulse_on, pulse_on_next;
  logic                   dir_reg, dir_reg_next;
  logic [COUNT_BITS-1:0]  step_total, step_total_next;
  logic                   done_flag, done_flag_next;

  logic                   s_accept;
  logic                   out_load;
  logic [COUNT_BITS-1:0]  in_count;
  logic                   in_dir;
  logic                   in_sw;

  logic [PERIOD_BITS-1:0] hi_eff, diff, high_t, tl_dec, low_t;
  logic [COUNT_BITS-1:0]  idx_inc, total_cur, mv_accel, mv_const;
  logic [COUNT_BITS:0]    two_ramp, n_minus;

  logic                   step_go, end_go, begin_go;
  phase_t                 begin_from, run_phase;

  logic                   md_start, md_done;
  logic [PERIOD_BITS-1:0] md_quo;

  function automatic phase_t first_run(input phase_t p, input logic a_nz, input logic c_nz);
    phase_t r;
    r = PH_IDLE;
    unique case (p)
      PH_ACCEL: r = a_nz ? PH_ACCEL : (c_nz ? PH_CONST : PH_IDLE);
      PH_CONST: r = c_nz ? PH_CONST : (a_nz ? PH_DECEL : PH_IDLE);
      PH_DECEL: r = a_nz ? PH_DECEL : PH_IDLE;
      default:  r = PH_IDLE;
    endcase
    return r;
  endfunction

  assign s_tready  = fsm == FSM_READY;
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign in_count  = s_tdata[COUNT_BITS-1:0];
  assign in_dir    = s_tdata[COUNT_BITS];
  assign in_sw     = s_tdata[COUNT_BITS+1];

  assign hi_eff    = (max_period > min_period) ? max_period : min_period;
  assign diff      = hi_eff - min_period;
  assign high_t    = (pulse_high != '0) ? pulse_high : PERIOD_BITS'(1);
  assign tl_dec    = (tick_left != '0) ? tick_left - 1'b1 : '0;
  assign low_t     = (cur_period > high_t) ? cur_period - high_t : '0;
  assign idx_inc   = phase_index + 1'b1;
  assign total_cur = (phase == PH_CONST) ? const_total : accel_total;

  assign two_ramp  = {ramp_steps, 1'b0};
  assign n_minus   = {1'b0, in_count} - two_ramp;
  assign mv_accel  = ({1'b0, in_count} < two_ramp) ? (in_count >> 1) : ramp_steps;
  assign mv_const  = ({1'b0, in_count} >= two_ramp) ? n_minus[COUNT_BITS-1:0] :
                     (in_count < ramp_steps) ? COUNT_BITS'(in_count[0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period  <= PERIOD_BITS'(DEF_MIN_PERIOD);
      max_period  <= PERIOD_BITS'(DEF_MAX_PERIOD);
      ramp_steps  <= COUNT_BITS'(DEF_RAMP_STEPS);
      pulse_high  <= PERIOD_BITS'(DEF_PULSE_HIGH);
      home_period <= PERIOD_BITS'(DEF_HOME_PERIOD);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PERIOD:  min_period  <= cfg_data[PERIOD_BITS-1:0];
        REG_MAX_PERIOD:  max_period  <= cfg_data[PERIOD_BITS-1:0];
        REG_RAMP_STEPS:  ramp_steps  <= cfg_data[COUNT_BITS-1:0];
        REG_PULSE_HIGH:  pulse_high  <= cfg_data[PERIOD_BITS-1:0];
        REG_HOME_PERIOD: home_period <= cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm         <= FSM_READY;
      phase       <= PH_IDLE;
      phase_index <= '0;
      accel_total <= '0;
      const_total <= '0;
      tick_left   <= '0;
      cur_period  <= '0;
      pulse_on    <= 1'b0;
      dir_reg     <= 1'b0;
      step_total  <= '0;
      done_flag   <= 1'b0;
    end else begin
      fsm         <= fsm_next;
      phase       <= phase_next;
      phase_index <= phase_index_next;
      accel_total <= accel_total_next;
      const_total <= const_total_next;
      tick_left   <= tick_left_next;
      cur_period  <= cur_period_next;
      pulse_on    <= pulse_on_next;
      dir_reg     <= dir_reg_next;
      step_total  <= step_total_next;
      done_flag   <= done_flag_next;
    end
  end

  always_comb begin
    fsm_next         = fsm;
    phase_next       = phase;
    phase_index_next = phase_index;
    accel_total_next = accel_total;
    const_total_next = const_total;
    tick_left_next   = tick_left;
    cur_period_next  = cur_period;
    pulse_on_next    = pulse_on;
    dir_reg_next     = dir_reg;
    step_total_next  = step_total;
    done_flag_next   = done_flag;
    step_go          = 1'b0;
    end_go           = 1'b0;
    begin_go         = 1'b0;
    begin_from       = PH_ACCEL;
    run_phase        = PH_IDLE;
    md_start         = 1'b0;
    out_load         = 1'b0;

    unique case (fsm)
      FSM_READY: begin
        if (s_accept) begin
          fsm_next       = FSM_FINISH;
          done_flag_next = 1'b0;
          case (s_tuser)
            ACT_TICK: begin
              if (phase != PH_IDLE) begin
                if (tl_dec != '0) begin
                  tick_left_next = tl_dec;
                end else if (pulse_on && low_t != '0) begin
                  pulse_on_next  = 1'b0;
                  tick_left_next = low_t;
                end else if (phase == PH_HOME) begin
                  if (!in_sw) end_go = 1'b1;
                  else step_go = 1'b1;
                end else if (idx_inc < total_cur) begin
                  phase_index_next = idx_inc;
                  step_go          = 1'b1;
                end else begin
                  begin_go = 1'b1;
                  unique case (phase)
                    PH_ACCEL: begin_from = PH_CONST;
                    PH_CONST: begin_from = PH_DECEL;
                    default:  begin_from = PH_IDLE;
                  endcase
                end
              end
            end
            ACT_MOVE: begin
              if (phase == PH_IDLE) begin
                dir_reg_next     = in_dir;
                step_total_next  = '0;
                accel_total_next = mv_accel;
                const_total_next = mv_const;
                begin_go         = 1'b1;
                begin_from       = PH_ACCEL;
              end
            end
            ACT_HOME: begin
              if (phase == PH_IDLE) begin
                dir_reg_next    = 1'b0;
                step_total_next = '0;
                if (!in_sw) begin
                  end_go = 1'b1;
                end else begin
                  phase_next       = PH_HOME;
                  phase_index_next = '0;
                  step_go          = 1'b1;
                end
              end
            end
            default: ;
          endcase

          if (begin_go) begin
            run_phase = first_run(begin_from, accel_total_next != '0,
                                  const_total_next != '0);
            if (run_phase == PH_IDLE) begin
              end_go = 1'b1;
            end else begin
              phase_next       = run_phase;
              phase_index_next = '0;
              step_go          = 1'b1;
            end
          end

          if (end_go) begin
            phase_next     = PH_IDLE;
            pulse_on_next  = 1'b0;
            tick_left_next = '0;
            done_flag_next = 1'b1;
          end

          if (step_go) begin
            pulse_on_next   = 1'b1;
            tick_left_next  = high_t;
            step_total_next = step_total_next + 1'b1;
            if (phase_next == PH_HOME) begin
              cur_period_next = home_period;
            end else if (phase_next == PH_CONST || accel_total_next == '0) begin
              cur_period_next = min_period;
            end else begin
              md_start = 1'b1;
              fsm_next = FSM_CALC;
            end
          end
        end
      end
      FSM_CALC: begin
        if (md_done) begin
          cur_period_next = (phase == PH_ACCEL) ? hi_eff - md_quo : min_period + md_quo;
          fsm_next        = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          fsm_next = FSM_READY;
        end
      end
      default: fsm_next = FSM_READY;
    endcase
  end

  tspg_muldiv #(
    .COUNT_BITS  (COUNT_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .diff     (diff),
    .index    (phase_index_next),
    .divisor  (accel_total_next),
    .done     (md_done),
    .quotient (md_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_W'({step_total, done_flag, phase != PH_IDLE, dir_reg, pulse_on});
    end
  end

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("slave side ready right after an accepted item");

  a_md_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    md_done |-> fsm == FSM_CALC)
    else $error("period unit finished outside the calc state");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (!pulse_on && tick_left == '0))
    else $error("pulse or tick count left over while idle");

  a_pulse_ticks: assert property (@(posedge clk) disable iff (rst)
    pulse_on |-> tick_left != '0)
    else $error("pulse high with no ticks left");

  a_ramp_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ACCEL || phase == PH_DECEL) |-> phase_index < accel_total)
    else $error("ramp index out of range");

endmodule
